[rtl/core/cnflp_pkg.sv]
// Package with the phase, result kind, character codes and shared structs of the CNF parser.
`timescale 1ns / 1ps

package cnflp_pkg;

    typedef enum logic [2:0]
    {
        PH_SEARCH,
        PH_VSKIP,
        PH_VDIGITS,
        PH_CSKIP,
        PH_CDIGITS,
        PH_LSKIP,
        PH_LITERAL,
        PH_DONE
    } phase_t;

    localparam logic [1:0] KIND_VARS    = 2'd0;
    localparam logic [1:0] KIND_CLAUSES = 2'd1;
    localparam logic [1:0] KIND_LIT     = 2'd2;
    localparam logic [1:0] KIND_END     = 2'd3;

    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed
    {
        logic [1:0]         kind;
        logic signed [31:0] value;
        logic [30:0]        clause_number;
        logic               done_res;
    } result_t;

    // Handshake between the parse core and the output register.
    typedef struct packed
    {
        logic valid;
        logic advance;
    } stage_ctl_t;

endpackage

[rtl/core/cnf_text_literal_parser.sv]
// Top level of the DIMACS CNF text parser: input register, parse core, result register.
// A byte held in the input register is parsed at the edge that also loads its result, if
// any, into the result register, which drives the output. Throughput: one byte per cycle,
// set by the combinational accumulate and compare; the input stalls only while a result
// waits under out_stall.
// Reset (rst_n, asynchronous, active low) returns to header search with cleared counters.
`timescale 1ns / 1ps

module cnf_text_literal_parser
    import cnflp_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         byte_req,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         kind,
    output logic signed [31:0] value,
    output logic [30:0]        clause_number,
    output logic               done_res
);

    // The input register holds one byte; the parse core consumes it whenever the result
    // register is free or is being emptied in the same cycle, so a new byte can be taken
    // while a finished result still waits downstream.
    stage_ctl_t ctl;
    logic       byte_valid;
    logic [7:0] byte_data;
    logic       fire;
    logic       res_valid;
    result_t    res;
    result_t    res_out;

    cnflp_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .byte_req   (byte_req),
        .advance    (ctl.advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    // A byte is parsed when it is present and the result register can take a result.
    assign fire = byte_valid && ctl.advance;

    cnflp_parse #(
        .VALUE_BITS (VALUE_BITS)
    ) u_parse
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .byte_data (byte_data),
        .res_valid (res_valid),
        .res       (res)
    );

    // The result register loads only for bytes that close a number.
    cnflp_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire && res_valid),
        .res       (res),
        .out_stall (out_stall),
        .ctl       (ctl),
        .res_out   (res_out)
    );

    assign out_valid     = ctl.valid;
    assign kind          = res_out.kind;
    assign value         = res_out.value;
    assign clause_number = res_out.clause_number;
    assign done_res      = res_out.done_res;

endmodule

[rtl/core/cnflp_in_stage.sv]
// Input register that holds one text byte while the parse stage is blocked.
`timescale 1ns / 1ps

module cnflp_in_stage
    import cnflp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] byte_req,
    input  logic       advance,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       accept;

    assign in_stall   = valid_reg && !advance;
    assign accept     = in_valid && !in_stall;
    assign valid_next = accept ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= byte_req;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

endmodule

[rtl/core/cnflp_parse.sv]
// Parse core: header search, number accumulation and clause bookkeeping for one byte a cycle while fire is high.
`timescale 1ns / 1ps

module cnflp_parse
    import cnflp_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] byte_data,
    output logic       res_valid,
    output result_t    res
);

    localparam int LIM_BITS = ((VALUE_BITS > 32) ? 32 : VALUE_BITS) - 1;
    localparam int ACC_WIDE = LIM_BITS + 4;

    phase_t              phase_reg,  phase_next;
    logic [31:0]         window_reg, window_next;
    logic [LIM_BITS-1:0] acc_reg,    acc_next;
    logic                neg_reg,    neg_next;
    logic [LIM_BITS-1:0] target_reg, target_next;
    logic [LIM_BITS-1:0] index_reg,  index_next;

    logic                is_digit;
    logic [LIM_BITS-1:0] digit_val;
    logic [ACC_WIDE-1:0] acc_wide;
    logic [ACC_WIDE-1:0] acc_sum;
    logic [LIM_BITS-1:0] acc_sat;
    logic                header_hit;
    phase_t              skip_phase;
    logic [LIM_BITS-1:0] skip_acc;
    logic                skip_neg;
    logic [31:0]         acc_ext;

    assign is_digit  = (byte_data >= CH_ZERO) && (byte_data <= CH_NINE);
    assign digit_val = LIM_BITS'(byte_data[3:0]);

    // acc * 10 + digit as two shifts and an add, then clamp to the all-ones limit.
    assign acc_wide = ACC_WIDE'(acc_reg);
    assign acc_sum  = (acc_wide << 3) + (acc_wide << 1) + ACC_WIDE'(byte_data[3:0]);
    assign acc_sat  = (acc_sum[ACC_WIDE-1:LIM_BITS] != 4'd0) ? {LIM_BITS{1'b1}}
                                                              : acc_sum[LIM_BITS-1:0];

    assign header_hit = (window_reg[31:24] == CH_P) && (window_reg[15:8] == CH_C)
                     && (window_reg[7:0] == CH_N) && (byte_data == CH_F);

    assign acc_ext = 32'(acc_reg);

    // Start of a literal: a minus sign or a digit opens one, anything else keeps skipping.
    always_comb
    begin
        skip_phase = PH_LSKIP;
        skip_acc   = acc_reg;
        skip_neg   = neg_reg;
        if (byte_data == CH_MINUS)
        begin
            skip_phase = PH_LITERAL;
            skip_acc   = '0;
            skip_neg   = 1'b1;
        end
        else if (is_digit)
        begin
            skip_phase = PH_LITERAL;
            skip_acc   = digit_val;
            skip_neg   = 1'b0;
        end
    end

    // Next state.
    always_comb
    begin
        phase_next  = phase_reg;
        window_next = window_reg;
        acc_next    = acc_reg;
        neg_next    = neg_reg;
        target_next = target_reg;
        index_next  = index_reg;
        unique case (phase_reg)
            PH_SEARCH:
            begin
                if (header_hit)
                begin
                    phase_next  = PH_VSKIP;
                    window_next = '0;
                end
                else
                begin
                    window_next = {window_reg[23:0], byte_data};
                end
            end
            PH_VSKIP, PH_CSKIP:
            begin
                if (is_digit)
                begin
                    acc_next   = digit_val;
                    phase_next = (phase_reg == PH_VSKIP) ? PH_VDIGITS : PH_CDIGITS;
                end
            end
            PH_VDIGITS:
            begin
                if (is_digit)
                begin
                    acc_next = acc_sat;
                end
                else
                begin
                    phase_next = PH_CSKIP;
                end
            end
            PH_CDIGITS:
            begin
                if (is_digit)
                begin
                    acc_next = acc_sat;
                end
                else
                begin
                    target_next = acc_reg;
                    if (acc_reg == '0)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        index_next = LIM_BITS'(1);
                        phase_next = skip_phase;
                        acc_next   = skip_acc;
                        neg_next   = skip_neg;
                    end
                end
            end
            PH_LSKIP:
            begin
                phase_next = skip_phase;
                acc_next   = skip_acc;
                neg_next   = skip_neg;
            end
            PH_LITERAL:
            begin
                if (is_digit)
                begin
                    acc_next = acc_sat;
                end
                else if (acc_reg == '0 && index_reg >= target_reg)
                begin
                    phase_next = PH_DONE;
                end
                else
                begin
                    if (acc_reg == '0)
                    begin
                        index_next = index_reg + LIM_BITS'(1);
                    end
                    phase_next = skip_phase;
                    acc_next   = skip_acc;
                    neg_next   = skip_neg;
                end
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase
    end

    // Result of the byte being parsed.
    always_comb
    begin
        res_valid         = 1'b0;
        res.kind          = KIND_VARS;
        res.value         = $signed(acc_ext);
        res.clause_number = '0;
        res.done_res      = 1'b0;
        unique case (phase_reg)
            PH_VDIGITS:
            begin
                res_valid = !is_digit;
            end
            PH_CDIGITS:
            begin
                res_valid    = !is_digit;
                res.kind     = KIND_CLAUSES;
                res.done_res = (acc_reg == '0);
            end
            PH_LITERAL:
            begin
                res_valid         = !is_digit;
                res.clause_number = 31'(index_reg);
                if (acc_reg != '0)
                begin
                    res.kind  = KIND_LIT;
                    res.value = neg_reg ? -$signed(acc_ext) : $signed(acc_ext);
                end
                else
                begin
                    res.kind     = KIND_END;
                    res.value    = '0;
                    res.done_res = (index_reg >= target_reg);
                end
            end
            PH_SEARCH, PH_VSKIP, PH_CSKIP, PH_LSKIP, PH_DONE:
            begin
                res_valid = 1'b0;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SEARCH;
            window_reg <= '0;
            acc_reg    <= '0;
            neg_reg    <= 1'b0;
            target_reg <= '0;
            index_reg  <= '0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            window_reg <= window_next;
            acc_reg    <= acc_next;
            neg_reg    <= neg_next;
            target_reg <= target_next;
            index_reg  <= index_next;
        end
    end

    // A finished parse never leaves the done phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(phase_reg) == PH_DONE |-> phase_reg == PH_DONE)
        else $error("cnflp_parse: left the done phase");

    // Done is only signaled on a clause count or a clause end.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.done_res |-> res.kind == KIND_CLAUSES || res.kind == KIND_END)
        else $error("cnflp_parse: done on a wrong result kind");

    // Once literals are being parsed, the clause index stays within the clause count.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_LSKIP || phase_reg == PH_LITERAL
        |-> index_reg != '0 && index_reg <= target_reg)
        else $error("cnflp_parse: clause index out of range");

endmodule

[rtl/core/cnflp_out_reg.sv]
// Result register that holds one result until the downstream side takes it.
`timescale 1ns / 1ps

module cnflp_out_reg
    import cnflp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  result_t    res,
    input  logic       out_stall,
    output stage_ctl_t ctl,
    output result_t    res_out
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign ctl.advance = !valid_reg || !out_stall;
    assign ctl.valid   = valid_reg;
    assign valid_next  = load ? 1'b1 : (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign res_out = res_reg;

endmodule
